// File: hw/rtl/ncfd_pkg.sv
// Shared constants and types for the nibble-complement frame decoder.
// Used by the window cell, the output cell and the top level; no dependencies.
`timescale 1ns / 1ps

package ncfd_pkg;

   // Largest payload length and the window that holds the longest frame.
   localparam int MAX_PAYLOAD = 16;
   localparam int WIN_DEPTH   = 2 * MAX_PAYLOAD + 3;

   // Widths; LEN_W, IDX_W and FILL_W are derived from the sizes above.
   localparam int CFG_W  = 5;
   localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int IDX_W  = $clog2(WIN_DEPTH);
   localparam int FILL_W = $clog2(WIN_DEPTH + 1);
   localparam int BIDX_W = 4;

   // Frame delimiters.
   localparam logic [7:0] HDR_BYTE = 8'h53;
   localparam logic [7:0] TRL_BYTE = 8'h43;
   localparam logic [3:0] HDR_NIB  = HDR_BYTE[7:4];
   localparam logic [3:0] TRL_NIB  = TRL_BYTE[3:0];

   // One decoded payload byte with its position and end marker.
   typedef struct packed {
      logic [7:0]        data_byte;
      logic [BIDX_W-1:0] byte_index;
      logic              last;
   } out_item_type;

   // Per-cycle control for the output cell chain.
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

// File: hw/rtl/nibble_complement_frame_decoder.sv
// A frame is checked once the pending flag registers the transaction that
// completes it; on a match its payload loads into the output chain and the
// bytes then leave one per cycle while rsp_ready is high. The input takes no
// new byte until the last one is checked, nor while a frame drains or stalls.
// The first byte shifts down MAX_PAYLOAD - N cells before it reaches the port.
// Reset: synchronous, clears the fill count, the pending flag, output valids and sets N to 16.
`timescale 1ns / 1ps

module nibble_complement_frame_decoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_data_byte,
   output logic [ncfd_pkg::BIDX_W-1:0]  rsp_byte_index,
   output logic                         rsp_last,
   input  logic                         csr_wr_en,
   input  logic [ncfd_pkg::CFG_W-1:0]   csr_wr_data
);
   import ncfd_pkg::*;

   localparam logic [IDX_W-1:0]  HDR_TOP  = IDX_W'(WIN_DEPTH - 3);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WIN_DEPTH);

   logic [CFG_W-1:0]  len_ff;
   logic [CFG_W-1:0]  len_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              pend_ff;
   logic              pend_in;

   logic              req_fire;
   logic              rsp_fire;
   logic [LEN_W-1:0]  n_eff;
   logic [FILL_W-1:0] flen;
   logic [IDX_W-1:0]  hdr_idx;
   logic [IDX_W-1:0]  nib_idx;

   logic [7:0]           win_q   [WIN_DEPTH];
   logic [7:0]           win_d   [WIN_DEPTH];
   logic [WIN_DEPTH-1:0] hdr_hit;
   logic [WIN_DEPTH-1:0] nib_hit;
   logic [WIN_DEPTH-1:0] pair_ok;
   logic [WIN_DEPTH-1:0] pair_need;

   logic hdr_ok;
   logic trl_ok;
   logic pairs_ok;
   logic fill_ok;
   logic match;

   cell_ctl_type          out_ctl;
   out_item_type          out_item  [MAX_PAYLOAD];
   logic [MAX_PAYLOAD-1:0] out_v;
   out_item_type          load_item [MAX_PAYLOAD];
   logic [MAX_PAYLOAD-1:0] load_v;

   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid & rsp_ready;
   assign req_ready = ~pend_ff & ~(|out_v);

   // Payload length register.
   assign len_in = csr_wr_en ? csr_wr_data : len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= CFG_W'(16);
      end else begin
         len_ff <= len_in;
      end
   end

   // Fill count saturates at the window depth; the check runs the cycle after.
   always_comb begin
      fill_in = fill_ff;
      if (req_fire && (fill_ff != FILL_MAX)) begin
         fill_in = fill_ff + FILL_W'(1);
      end
      pend_in = req_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         pend_ff <= pend_in;
      end
   end

   // Receive window: a row of byte cells, newest byte at the top index.
   genvar gw;
   generate
      for (gw = 0; gw < WIN_DEPTH; gw++) begin : g_win
         if (gw == WIN_DEPTH - 1) begin : g_top
            assign win_d[gw] = req_rx_byte;
         end else begin : g_mid
            assign win_d[gw] = win_q[gw + 1];
         end
         ncfd_win_cell u_cell (
            .clock       (clock),
            .shift_en    (req_fire),
            .din         (win_d[gw]),
            .q           (win_q[gw]),
            .hdr_hit     (hdr_hit[gw]),
            .hdr_nib_hit (nib_hit[gw]),
            .pair_ok     (pair_ok[gw])
         );
      end
   endgenerate

   // Effective length and frame geometry; the trailer always sits at the top.
   assign n_eff   = (int'(len_ff) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : LEN_W'(len_ff);
   assign flen    = FILL_W'({n_eff, 1'b0}) + FILL_W'(3);
   assign hdr_idx = HDR_TOP - IDX_W'({n_eff, 1'b0});
   assign nib_idx = hdr_idx + IDX_W'(1);

   // Complement pairs are required from the second frame byte up to the
   // byte just below the trailer.
   always_comb begin
      pair_need = '0;
      for (int j = 0; j < WIN_DEPTH - 2; j++) begin
         pair_need[j] = (IDX_W'(j) > hdr_idx);
      end
   end

   assign pairs_ok = &(pair_ok | ~pair_need);
   assign hdr_ok   = hdr_hit[hdr_idx] & nib_hit[nib_idx];
   assign trl_ok   = (win_q[WIN_DEPTH-1] == TRL_BYTE) &&
                     (win_q[WIN_DEPTH-2][7:4] == TRL_NIB);
   assign fill_ok  = (fill_ff >= flen);
   assign match    = pend_ff & (n_eff != '0) & fill_ok & hdr_ok & trl_ok & pairs_ok;

   // Output chain: the last payload byte lands in the top cell and the frame
   // drains toward cell zero, which drives the result port.
   assign out_ctl.load  = match;
   assign out_ctl.shift = rsp_ready | ~out_v[0];

   genvar go;
   generate
      for (go = 0; go < MAX_PAYLOAD; go++) begin : g_out
         localparam int M = MAX_PAYLOAD - 1 - go;
         logic [LEN_W-1:0] pos;
         out_item_type     up_item;
         logic             up_v;

         assign pos = n_eff - LEN_W'(M + 1);
         assign load_v[go]               = (LEN_W'(M) < n_eff);
         assign load_item[go].data_byte  = {win_q[WIN_DEPTH-4-2*M][7:4],
                                            win_q[WIN_DEPTH-3-2*M][7:4]};
         assign load_item[go].byte_index = BIDX_W'(pos);
         assign load_item[go].last       = (M == 0);

         if (go == MAX_PAYLOAD - 1) begin : g_top
            assign up_item = '0;
            assign up_v    = 1'b0;
         end else begin : g_mid
            assign up_item = out_item[go + 1];
            assign up_v    = out_v[go + 1];
         end

         ncfd_out_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (out_ctl),
            .load_item  (load_item[go]),
            .load_valid (load_v[go]),
            .up_item    (up_item),
            .up_valid   (up_v),
            .item       (out_item[go]),
            .valid      (out_v[go])
         );
      end
   endgenerate

   assign rsp_valid      = out_v[0];
   assign rsp_data_byte  = out_item[0].data_byte;
   assign rsp_byte_index = out_item[0].byte_index;
   assign rsp_last       = out_item[0].last;

   // A frame check never overlaps a frame still draining.
   a_pend_idle : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !(|out_v))
      else $error("frame check while output chain busy");

   // A check cycle is always followed by a non-check cycle.
   a_pend_once : assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> !pend_ff)
      else $error("frame check repeated");

   // Once a frame starts coming out, its bytes are contiguous.
   a_no_gap : assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_last) |=> rsp_valid)
      else $error("gap inside a decoded frame");

   // Byte positions count up by one within a frame.
   a_index_step : assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_last) |=>
         (rsp_byte_index == $past(rsp_byte_index) + BIDX_W'(1)))
      else $error("byte index did not advance");

endmodule

// File: hw/rtl/ncfd_win_cell.sv
// One byte cell of the receive window shift chain.
// Depends on ncfd_pkg for the delimiter constants.
`timescale 1ns / 1ps

module ncfd_win_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] din,
   output logic [7:0] q,
   output logic       hdr_hit,
   output logic       hdr_nib_hit,
   output logic       pair_ok
);
   import ncfd_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // Take the byte on din (the newer neighbor's, or the incoming byte at the top) on every accepted transaction.
   assign byte_in = shift_en ? din : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign q = byte_ff;

   // Local checks: header byte, second-byte nibble, and the complement rule
   // between this byte's high nibble and the newer neighbor's low nibble.
   assign hdr_hit     = (byte_ff == HDR_BYTE);
   assign hdr_nib_hit = (byte_ff[3:0] == HDR_NIB);
   assign pair_ok     = (byte_ff[7:4] == ~din[3:0]);

endmodule

// File: hw/rtl/ncfd_out_cell.sv
// One cell of the output chain that holds a decoded payload byte.
// Depends on ncfd_pkg for the item and control types.
`timescale 1ns / 1ps

module ncfd_out_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  ncfd_pkg::cell_ctl_type  ctl,
   input  ncfd_pkg::out_item_type  load_item,
   input  logic                    load_valid,
   input  ncfd_pkg::out_item_type  up_item,
   input  logic                    up_valid,
   output ncfd_pkg::out_item_type  item,
   output logic                    valid
);
   import ncfd_pkg::*;

   out_item_type item_ff;
   out_item_type item_in;
   logic         valid_ff;
   logic         valid_in;

   // Load a fresh frame, or move one step toward the output end; otherwise hold.
   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff;
      if (ctl.load) begin
         item_in  = load_item;
         valid_in = load_valid;
      end else if (ctl.shift) begin
         item_in  = up_item;
         valid_in = up_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign item  = item_ff;
   assign valid = valid_ff;

endmodule

// File: dv/tb_nibble_complement_frame_decoder.sv
// Self-checking testbench for the nibble-complement frame decoder.
// Depends on ncfd_pkg and nibble_complement_frame_decoder; uses no files or arguments.
`timescale 1ns / 1ps

module tb_nibble_complement_frame_decoder;
   import ncfd_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 2 * MAX_PAYLOAD + 8;
   localparam int LONG_STALL = 500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_data_byte;
   logic [BIDX_W-1:0] rsp_byte_index;
   logic rsp_last;
   logic csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   // Bytes waiting to be sent and decoded bytes still owed by the block.
   logic [7:0] pending_bytes[$];
   out_item_type expected_payload[$];
   int queued_total = 0;

   // Shadow copy of the decoder state.
   logic [7:0] rx_window[0:WIN_DEPTH-1];
   int fill_count = 0;
   logic [CFG_W-1:0] cfg_len = 5'd16;

   int fail_count = 0;
   int cycle_count = 0;
   bit idle_en = 1'b1;
   int send_gap = 0;
   int recv_gap = 0;
   int stall_requests = 0;
   int stall_served = 0;
   int stall_left = 0;

   nibble_complement_frame_decoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data_byte(rsp_data_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shift one received byte into the window and queue the payload of any frame it completes.
   task automatic decode_rx_byte(input logic [7:0] rx);
      int n;
      int flen;
      int base;
      int k;
      logic ok;
      out_item_type item;
      for (k = 0; k < WIN_DEPTH - 1; k++) rx_window[k] = rx_window[k + 1];
      rx_window[WIN_DEPTH - 1] = rx;
      if (fill_count < WIN_DEPTH) fill_count++;
      n = (cfg_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cfg_len);
      if (n == 0) return;
      flen = 2 * n + 3;
      if (fill_count < flen) return;
      base = WIN_DEPTH - flen;
      ok = (rx_window[base] == HDR_BYTE) && (rx_window[base + 1][3:0] == HDR_NIB) &&
           (rx_window[base + flen - 2][7:4] == TRL_NIB) &&
           (rx_window[base + flen - 1] == TRL_BYTE);
      // Each high nibble must be the complement of the next byte's low nibble.
      for (k = 0; k < 2 * n; k++) begin
         if (rx_window[base + k + 1][7:4] != ~rx_window[base + k + 2][3:0]) ok = 1'b0;
      end
      if (!ok) return;
      for (k = 0; k < n; k++) begin
         item.data_byte = {rx_window[base + 2 * k + 1][7:4], rx_window[base + 2 * k + 2][7:4]};
         item.byte_index = k[BIDX_W-1:0];
         item.last = (k == n - 1);
         expected_payload.push_back(item);
      end
   endtask

   // Encode a frame of n payload bytes; a fixed value below zero means random payload,
   // and a damage position of zero or more flips the masked bits of that frame byte.
   task automatic queue_frame(input int n, input int fixed, input int bad_pos,
                              input logic [7:0] bad_mask);
      logic [7:0] frame_bytes[0:WIN_DEPTH-1];
      logic [7:0] pay;
      logic [3:0] hi;
      logic [3:0] prev_hi;
      int j;
      pay = 8'h00;
      prev_hi = 4'h0;
      frame_bytes[0] = HDR_BYTE;
      for (j = 1; j <= 2 * n + 1; j++) begin
         if (j % 2 == 1 && j < 2 * n + 1)
            pay = (fixed < 0) ? 8'($urandom_range(0, 255)) : fixed[7:0];
         if (j == 2 * n + 1) hi = TRL_NIB;
         else if (j % 2 == 1) hi = pay[7:4];
         else hi = pay[3:0];
         frame_bytes[j] = {hi, (j == 1) ? HDR_NIB : ~prev_hi};
         prev_hi = hi;
      end
      frame_bytes[2 * n + 2] = TRL_BYTE;
      if (bad_pos >= 0) frame_bytes[bad_pos] = frame_bytes[bad_pos] ^ bad_mask;
      for (j = 0; j <= 2 * n + 2; j++) begin
         pending_bytes.push_back(frame_bytes[j]);
         queued_total++;
      end
   endtask

   // Sender stops offering, all decoded bytes come back, then the block gets time to settle.
   task automatic wait_for_idle();
      while (pending_bytes.size() != 0 || req_valid || expected_payload.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_payload_len(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_len = value;
   endtask

   // Input driver: holds each byte until accepted, with random idle bursts between transactions.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) decode_rx_byte(req_rx_byte);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 17) - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_valid <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Output monitor: checks each transaction against the oldest expected byte and drives ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_payload.size() == 0) begin
               $display("%0t: unexpected output, expected none, actual data %02h index %0d last %0b",
                        $time, rsp_data_byte, rsp_byte_index, rsp_last);
               fail_count++;
            end else begin
               out_item_type exp_item;
               exp_item = expected_payload.pop_front();
               if (rsp_data_byte !== exp_item.data_byte) begin
                  $display("%0t: data_byte mismatch, expected %02h, actual %02h",
                           $time, exp_item.data_byte, rsp_data_byte);
                  fail_count++;
               end
               if (rsp_byte_index !== exp_item.byte_index) begin
                  $display("%0t: byte_index mismatch, expected %0d, actual %0d",
                           $time, exp_item.byte_index, rsp_byte_index);
                  fail_count++;
               end
               if (rsp_last !== exp_item.last) begin
                  $display("%0t: last mismatch, expected %0b, actual %0b",
                           $time, exp_item.last, rsp_last);
                  fail_count++;
               end
            end
         end
         // A long hold-off takes priority over the short random bursts.
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (stall_served != stall_requests) begin
            stall_served++;
            stall_left = LONG_STALL - 1;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (idle_en && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 17) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_nibble_complement_frame_decoder failed");
         $finish;
      end
   end

   // Stimulus: directed frames first, then random phases over several payload lengths.
   initial begin
      int phase_len[10];
      int phase;
      int start;
      int quota;
      int n;
      int pick;
      int k;
      phase_len = '{2, 31, 3, 0, 17, 5, 16, 4, 1, 7};
      for (k = 0; k < WIN_DEPTH; k++) rx_window[k] = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Shortest frames: all-zero and all-one payload, a broken nibble chain, a bad trailer.
      write_payload_len(5'd1);
      queue_frame(1, 8'h00, -1, 8'h00);
      queue_frame(1, 8'hFF, -1, 8'h00);
      queue_frame(1, 8'h3C, 2, 8'h01);
      queue_frame(1, 8'hA5, 4, 8'h80);
      wait_for_idle();
      // Zero length never reports a frame, even a well-formed one.
      write_payload_len(5'd0);
      queue_frame(1, 8'h5A, -1, 8'h00);
      wait_for_idle();

      for (phase = 0; phase < 10; phase++) begin
         write_payload_len(phase_len[phase][CFG_W-1:0]);
         idle_en = (phase < 8);
         quota = (phase == 2) ? 90 : 25;
         // Hold the output off long enough for the block to fill and stall its input.
         if (phase == 2) stall_requests++;
         start = queued_total;
         while (queued_total - start < quota) begin
            n = (phase_len[phase] > MAX_PAYLOAD) ? MAX_PAYLOAD : phase_len[phase];
            pick = $urandom_range(0, 7);
            if (n == 0 || pick == 3) n = $urandom_range(1, 4);
            if (pick == 0) begin
               repeat ($urandom_range(1, 4)) begin
                  pending_bytes.push_back(8'($urandom_range(0, 255)));
                  queued_total++;
               end
            end else if (pick <= 2) begin
               queue_frame(n, -1, $urandom_range(0, 2 * n + 2), 8'h01 << $urandom_range(0, 7));
            end else begin
               queue_frame(n, -1, -1, 8'h00);
            end
         end
         wait_for_idle();
      end

      if (fail_count == 0) begin
         $display("tb_nibble_complement_frame_decoder passed");
      end else begin
         $display("tb_nibble_complement_frame_decoder failed");
      end
      $finish;
   end

endmodule

// File: nibble_complement_frame_decoder.f
hw/rtl/ncfd_pkg.sv
hw/rtl/ncfd_win_cell.sv
hw/rtl/ncfd_out_cell.sv
hw/rtl/nibble_complement_frame_decoder.sv
dv/tb_nibble_complement_frame_decoder.sv
